[design/stli_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package stli_pkg;
    localparam int TableDepth = 1024;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = IdxW + 1;
    localparam int CfgW = 11;
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CfgPointsInUse = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgNegate = 1'd1;
    localparam logic OpLoad = 1'b0;
    localparam logic OpQuery = 1'b1;
    localparam int QuoBits = 34;
    localparam int QuoCntW = 6;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_RD_FIRST,
        t_ST_RD_LAST,
        t_ST_CHECK,
        t_ST_PROBE,
        t_ST_PROBE_CMP,
        t_ST_RD_SEG,
        t_ST_SEG_LO,
        t_ST_SEG_HI,
        t_ST_DIV,
        t_ST_FINISH,
        t_ST_OUT
    } t_state;
endpackage
`default_nettype wire

[design/sorted_table_linear_interpolator.sv]
// Piecewise linear interpolation over a table of up to 1024 points.
// Input channel (i_valid/o_stall): opcode 0 loads point entry_index with
// point_key and point_value; opcode 1 queries point_key. Loads give no result.
// A query returns one item on the output channel (o_valid/i_stall) holding
// result_value and out_of_range.
// Keys unsigned in 1/256 units, values signed Q24.8; steps truncate toward zero.
// A query first reads the first and last keys, then runs the binary search,
// a probe state and a compare state per probe, through the single-port table
// memories, reads the segment, and runs a 34-step bit-serial division, one
// step per cycle. An exact hit or out-of-span key ends early. One item is
// handled at a time. The finished result sits in an output register while the
// next input item is already accepted; a stalled result holds its value until
// taken.
// Synchronous active-low reset returns the control to idle, the point count
// to 2 and negation off. Table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_linear_interpolator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [stli_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [stli_pkg::CfgW-1:0]      i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_opcode,
    input  wire logic [9:0]                     i_entry_index,
    input  wire logic [31:0]                    i_point_key,
    input  wire logic signed [31:0]             i_point_value,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [31:0]                  o_result_value,
    output logic                                o_out_of_range
);
    import stli_pkg::*;

    logic [31:0] r_keys [TableDepth];
    logic [31:0] r_vals [TableDepth];

    t_state r_state, n_state;
    logic [CfgW-1:0] r_points;
    logic r_negate;
    logic [31:0] r_key;
    logic [CntW-1:0] r_n;
    logic signed [CntW:0] r_low, r_high, r_mid;
    logic [31:0] r_kfirst, r_x1;
    logic signed [31:0] r_y1;
    logic [31:0] r_rdk;
    logic signed [31:0] r_rdv;
    logic [IdxW-1:0] mem_addr;
    logic mem_we;
    logic [32:0] r_span, r_off, r_rem;
    logic [33:0] r_mag, r_quo;
    logic r_neg_dy;
    logic r_interp;
    logic [QuoCntW-1:0] r_bit;
    logic signed [31:0] r_res;
    logic r_oor;
    logic signed [31:0] r_out_val;
    logic r_out_oor, r_out_valid;

    logic in_acc, out_acc, out_free;
    logic signed [CntW:0] mid_c, seg_c;
    logic signed [CntW:0] nm2;
    logic [CntW-1:0] n_clamp;
    logic [34:0] rem_a, rem_b;
    logic [33:0] quo_a;
    logic signed [33:0] dy;
    logic signed [32:0] sum;
    logic signed [31:0] neg_res;

    always_comb begin
        if (r_points < CfgW'(2)) begin
            n_clamp = CntW'(2);
        end else if (r_points > CfgW'(TableDepth)) begin
            n_clamp = CntW'(TableDepth);
        end else begin
            n_clamp = CntW'(r_points);
        end
    end

    assign o_stall = (r_state != t_ST_IDLE);
    assign in_acc = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid = r_out_valid;
    assign o_result_value = r_out_val;
    assign o_out_of_range = r_out_oor;

    assign mid_c = r_low + ((r_high - r_low) >>> 1);
    assign nm2 = $signed({1'b0, r_n}) - (CntW+1)'(2);

    always_comb begin
        seg_c = (r_rdk < r_key) ? r_mid : r_mid - (CntW+1)'(1);
        if (seg_c < 0) begin
            seg_c = '0;
        end
        if (seg_c > nm2) begin
            seg_c = nm2;
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_addr = i_entry_index;
        unique case (r_state)
            t_ST_IDLE: begin
                mem_we = in_acc && (i_opcode == OpLoad);
                mem_addr = in_acc && (i_opcode == OpQuery) ? '0 : i_entry_index;
            end
            t_ST_RD_FIRST, t_ST_RD_LAST: mem_addr = IdxW'(r_n - CntW'(1));
            t_ST_PROBE: mem_addr = IdxW'(mid_c);
            t_ST_RD_SEG: mem_addr = IdxW'(seg_c);
            t_ST_SEG_LO: mem_addr = IdxW'(r_mid + (CntW+1)'(1));
            default: mem_addr = IdxW'(r_mid);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_keys[mem_addr] <= i_point_key;
            r_vals[mem_addr] <= i_point_value;
        end
        r_rdk <= r_keys[mem_addr];
        r_rdv <= r_vals[mem_addr];
    end

    // One step of floor(off * mag / span): double, then add off if mag bit set.
    always_comb begin
        rem_a = {r_rem, 1'b0};
        quo_a = {r_quo[32:0], 1'b0};
        if (rem_a >= {2'b0, r_span}) begin
            rem_a = rem_a - {2'b0, r_span};
            quo_a = quo_a + 34'd1;
        end
        rem_b = rem_a;
        if (r_mag[r_bit]) begin
            rem_b = rem_a + {2'b0, r_off};
            if (rem_b >= {2'b0, r_span}) begin
                rem_b = rem_b - {2'b0, r_span};
                quo_a = quo_a + 34'd1;
            end
        end
    end

    assign dy = 34'(r_rdv) - 34'(r_y1);
    assign sum = r_neg_dy ? 33'(r_y1) - 33'(r_quo) : 33'(r_y1) + 33'(r_quo);
    assign neg_res = (r_res == 32'sh8000_0000) ? 32'sh7fff_ffff : -r_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_IDLE: begin
                if (in_acc && i_opcode == OpQuery) begin
                    n_state = t_ST_RD_FIRST;
                end
            end
            t_ST_RD_FIRST: n_state = t_ST_RD_LAST;
            t_ST_RD_LAST: n_state = t_ST_CHECK;
            t_ST_CHECK: begin
                n_state = (r_key < r_kfirst || r_key > r_rdk) ? t_ST_FINISH : t_ST_PROBE;
            end
            t_ST_PROBE: n_state = t_ST_PROBE_CMP;
            t_ST_PROBE_CMP: begin
                if (r_rdk == r_key) begin
                    n_state = t_ST_FINISH;
                end else if ((r_rdk > r_key && r_low > r_mid - 1)
                        || (r_rdk < r_key && r_mid + 1 > r_high)) begin
                    n_state = t_ST_RD_SEG;
                end else begin
                    n_state = t_ST_PROBE;
                end
            end
            t_ST_RD_SEG: n_state = t_ST_SEG_LO;
            t_ST_SEG_LO: n_state = t_ST_SEG_HI;
            t_ST_SEG_HI: n_state = (r_rdk <= r_x1) ? t_ST_FINISH : t_ST_DIV;
            t_ST_DIV: n_state = (r_bit == '0) ? t_ST_FINISH : t_ST_DIV;
            t_ST_FINISH: n_state = t_ST_OUT;
            t_ST_OUT: n_state = out_free ? t_ST_IDLE : t_ST_OUT;
            default: n_state = t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
            r_points <= CfgW'(2);
            r_negate <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == CfgPointsInUse) begin
                r_points <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CfgNegate) begin
                r_negate <= i_cfg_data[0];
            end
            if (r_state == t_ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            t_ST_IDLE: begin
                r_key <= i_point_key;
                r_n <= n_clamp;
                r_low <= '0;
                r_high <= $signed({1'b0, n_clamp}) - (CntW+1)'(1);
                r_oor <= 1'b0;
                r_interp <= 1'b0;
            end
            t_ST_RD_FIRST: r_kfirst <= r_rdk;
            t_ST_CHECK: begin
                if (r_key < r_kfirst || r_key > r_rdk) begin
                    r_oor <= 1'b1;
                    r_res <= '0;
                end
            end
            t_ST_PROBE: r_mid <= mid_c;
            t_ST_PROBE_CMP: begin
                if (r_rdk == r_key) begin
                    r_res <= r_rdv;
                end else if (r_rdk > r_key) begin
                    r_high <= r_mid - (CntW+1)'(1);
                end else begin
                    r_low <= r_mid + (CntW+1)'(1);
                end
            end
            t_ST_RD_SEG: r_mid <= seg_c;
            t_ST_SEG_LO: begin
                r_x1 <= r_rdk;
                r_y1 <= r_rdv;
            end
            t_ST_SEG_HI: begin
                r_res <= r_y1;
                r_interp <= (r_rdk > r_x1);
                r_span <= 33'(r_rdk) - 33'(r_x1);
                if (r_key <= r_x1) begin
                    r_off <= '0;
                end else if (r_key > r_rdk) begin
                    r_off <= 33'(r_rdk) - 33'(r_x1);
                end else begin
                    r_off <= 33'(r_key) - 33'(r_x1);
                end
                r_neg_dy <= dy[33];
                r_mag <= dy[33] ? 34'(-dy) : 34'(dy);
                r_rem <= '0;
                r_quo <= '0;
                r_bit <= QuoCntW'(QuoBits - 1);
            end
            t_ST_DIV: begin
                r_rem <= rem_b[32:0];
                r_quo <= quo_a;
                r_bit <= r_bit - QuoCntW'(1);
            end
            t_ST_FINISH: begin
                if (r_interp) begin
                    r_res <= sum[31:0];
                end
            end
            t_ST_OUT: begin
                if (out_free) begin
                    r_out_val <= (r_negate && !r_oor) ? neg_res : r_res;
                    r_out_oor <= r_oor;
                end
            end
            default: ;
        endcase
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_ST_DIV) |-> o_stall)
        else $error("input taken during division");
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_result_value == 32'sd0))
        else $error("out-of-range result not zero");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_ST_OUT && !out_free) |=> (r_state == t_ST_OUT))
        else $error("result dropped");
endmodule
`default_nettype wire
